@@ sv/brl_pkg.sv @@
// Shared types and constants for the Bresenham line rasterizer.
package brl_pkg;

	localparam int COORD_BITS  = 16;
	localparam int FIELD_BITS  = 16;
	localparam int COLOR_BITS  = 16;
	localparam int SCREEN_BITS = 11;
	localparam int CMP_BITS    = (COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS;

	localparam logic [SCREEN_BITS-1:0] WIDTH_RESET  = SCREEN_BITS'(480);
	localparam logic [SCREEN_BITS-1:0] HEIGHT_RESET = SCREEN_BITS'(320);

	// request command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	// configuration register indexes
	localparam logic REG_SCREEN_WIDTH  = 1'b0;
	localparam logic REG_SCREEN_HEIGHT = 1'b1;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic                         command;
		logic signed [FIELD_BITS-1:0] start_x;
		logic signed [FIELD_BITS-1:0] start_y;
		logic signed [FIELD_BITS-1:0] end_x;
		logic signed [FIELD_BITS-1:0] end_y;
		logic [COLOR_BITS-1:0]        line_color;
	} brl_cmd_t;

	typedef struct packed {
		logic signed [FIELD_BITS-1:0] pixel_x;
		logic signed [FIELD_BITS-1:0] pixel_y;
		logic [COLOR_BITS-1:0]        pixel_color;
		logic                         on_screen;
		logic                         last_pixel;
	} brl_pix_t;

	// walk state of the current line
	typedef struct packed {
		coord_t                major_pos;
		coord_t                minor_pos;
		coord_t                major_end;
		coord_t                major_delta;
		coord_t                minor_delta;
		coord_t                error_term;
		logic                  minor_goes_down;
		logic                  axes_swapped;
		logic                  line_active;
		logic [COLOR_BITS-1:0] held_color;
	} brl_line_t;

endpackage

@@ sv/brl_setup.sv @@
// Line setup: axis choice, endpoint ordering, deltas and initial error.
module brl_setup import brl_pkg::*; (
	input  brl_cmd_t  cmd,
	output brl_line_t line
);

	localparam int DB = COORD_BITS + 1;

	coord_t ax, ay, bx, by;
	logic signed [DB-1:0] dx, dy, dmaj, dmin;
	logic [DB-1:0] adx, ady, admaj, admin;
	logic steep, swap, dmin_neg, dmin_zero;
	coord_t p0, p1, q0, q1, mdelta, mdelta_adj;

	always_comb begin
		ax = $signed(cmd.start_x[COORD_BITS-1:0]);
		ay = $signed(cmd.start_y[COORD_BITS-1:0]);
		bx = $signed(cmd.end_x[COORD_BITS-1:0]);
		by = $signed(cmd.end_y[COORD_BITS-1:0]);
		dx = DB'(bx) - DB'(ax);
		dy = DB'(by) - DB'(ay);
		adx = dx[DB-1] ? DB'(-dx) : DB'(dx);
		ady = dy[DB-1] ? DB'(-dy) : DB'(dy);
		steep = ady > adx;
		dmaj  = steep ? dy : dx;
		dmin  = steep ? dx : dy;
		admaj = steep ? ady : adx;
		admin = steep ? adx : ady;
		p0 = steep ? ay : ax;
		p1 = steep ? by : bx;
		q0 = steep ? ax : ay;
		q1 = steep ? bx : by;
		// endpoints run backward along the major axis: walk from the far end
		swap = dmaj[DB-1];
		dmin_neg  = dmin[DB-1];
		dmin_zero = (dmin == '0);
		mdelta = $signed(admaj[COORD_BITS-1:0]);
		// signed halving that truncates toward zero
		mdelta_adj = mdelta + COORD_BITS'(mdelta[COORD_BITS-1]);

		line.major_pos       = swap ? p1 : p0;
		line.major_end       = swap ? p0 : p1;
		line.minor_pos       = swap ? q1 : q0;
		line.major_delta     = mdelta;
		line.minor_delta     = $signed(admin[COORD_BITS-1:0]);
		line.error_term      = mdelta_adj >>> 1;
		line.minor_goes_down = swap ? !dmin_neg : (dmin_neg | dmin_zero);
		line.axes_swapped    = steep;
		line.line_active     = 1'b1;
		line.held_color      = cmd.line_color;
	end

endmodule

@@ sv/brl_step.sv @@
// One walk step: current pixel with clip and last flags, next walk state.
module brl_step import brl_pkg::*; (
	input  brl_line_t              line,
	input  logic [SCREEN_BITS-1:0] screen_width,
	input  logic [SCREEN_BITS-1:0] screen_height,
	output brl_pix_t               pix,
	output brl_line_t              line_next
);

	coord_t x, y, err_sub, minor_inc;
	logic x_in, y_in, last;

	always_comb begin
		x = line.axes_swapped ? line.minor_pos : line.major_pos;
		y = line.axes_swapped ? line.major_pos : line.minor_pos;
		x_in = !x[COORD_BITS-1] &&
			(CMP_BITS'(x[COORD_BITS-1:0]) < CMP_BITS'(screen_width));
		y_in = !y[COORD_BITS-1] &&
			(CMP_BITS'(y[COORD_BITS-1:0]) < CMP_BITS'(screen_height));
		last = line.major_pos >= line.major_end;

		pix.pixel_x     = FIELD_BITS'(x);
		pix.pixel_y     = FIELD_BITS'(y);
		pix.pixel_color = line.held_color;
		pix.on_screen   = x_in & y_in;
		pix.last_pixel  = last;

		line_next = line;
		err_sub = line.error_term - line.minor_delta;
		minor_inc = line.minor_goes_down ? '1 : COORD_BITS'(1);
		if (err_sub[COORD_BITS-1]) begin
			line_next.minor_pos  = line.minor_pos + minor_inc;
			line_next.error_term = err_sub + line.major_delta;
		end else begin
			line_next.error_term = err_sub;
		end
		if (last) begin
			line_next.line_active = 1'b0;
		end else begin
			line_next.major_pos = line.major_pos + COORD_BITS'(1);
		end
	end

endmodule

@@ sv/bresenham_line_rasterizer.sv @@
// Top level of the Bresenham line rasterizer with screen clipping.
// A load request (command 0) takes two endpoints and a color and sets up an integer
// Bresenham walk in the same cycle; it produces no pixel. Each step request
// (command 1) produces the next pixel of the line: position, color, an on_screen
// flag (0 <= x < screen_width, 0 <= y < screen_height) and last_pixel on the final
// pixel. Steps while no line is active are taken and dropped; a load during a
// line replaces it. Coordinates wrap as two's complement of COORD_BITS bits.
// The walk state register feeds the step logic; the setup and step logic write back
// to it, and the step logic feeds the pixel output register, so a request is
// taken every cycle as long as the pixel register is empty or being drained.
// screen_width and screen_height reset to 480 and 320 and are written through
// cfg_we/cfg_index/cfg_data; only while idle, which the user ensures, not the block.
module bresenham_line_rasterizer import brl_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_ready,
	input  brl_cmd_t               cmd,
	output logic                   pix_valid,
	input  logic                   pix_ready,
	output brl_pix_t               pix,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [SCREEN_BITS-1:0] cfg_data
);

	logic [SCREEN_BITS-1:0] screen_width_q, screen_height_q;
	brl_line_t line_q, setup_line, step_line;
	brl_pix_t  step_pix, pix_q;
	logic      pix_valid_q;
	logic      accept, is_load, emit;

	brl_setup u_setup (
		.cmd  (cmd),
		.line (setup_line)
	);

	brl_step u_step (
		.line          (line_q),
		.screen_width  (screen_width_q),
		.screen_height (screen_height_q),
		.pix           (step_pix),
		.line_next     (step_line)
	);

	// output register drains in the same cycle it refills
	assign cmd_ready = !pix_valid_q || pix_ready;
	assign accept    = cmd_valid && cmd_ready;
	assign is_load   = (cmd.command == CMD_LOAD);
	assign emit      = accept && (cmd.command == CMD_STEP) && line_q.line_active;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= WIDTH_RESET;
			screen_height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data;
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// walk state: load replaces it, an active step advances it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= '0;
		end else if (accept && is_load) begin
			line_q <= setup_line;
		end else if (emit) begin
			line_q <= step_line;
		end
	end

	// pixel output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (emit) begin
			pix_valid_q <= 1'b1;
		end else if (pix_ready) begin
			pix_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pix_q <= step_pix;
		end
	end

	assign pix_valid = pix_valid_q;
	assign pix       = pix_q;

endmodule

@@ sim/bresenham_line_rasterizer_tb.sv @@
// Self-checking testbench for the Bresenham line rasterizer: line walks, clipping, handshakes.
module bresenham_line_rasterizer_tb;
	import brl_pkg::*;

	localparam int CLK_PERIOD     = 8;
	localparam int RESET_CYCLES   = 8;
	localparam int SETTLE_CYCLES  = 4;      // settle time after the owed pixels are out
	localparam int LONG_HOLD      = 400;    // pixel side stall long enough to back up requests
	localparam int HOLD_AFTER     = 300;    // pixels checked before that stall starts
	localparam int PHASE_REQUESTS = 200;
	localparam int PHASES         = 8;
	localparam int TIMEOUT_CYCLES = 500_000;

	// Walk predictor plus the queue of pixels still owed by the block.
	class line_pixel_scoreboard;
		int        screen_w;
		int        screen_h;
		coord_t    major_pos;
		coord_t    minor_pos;
		coord_t    major_end;
		coord_t    major_delta;
		coord_t    minor_delta;
		coord_t    err_acc;
		bit        minor_down;
		bit        swapped;
		bit        active;
		logic [COLOR_BITS-1:0] color;
		brl_pix_t  expected_pixels[$];
		int        errors;

		function new();
			screen_w    = int'(WIDTH_RESET);
			screen_h    = int'(HEIGHT_RESET);
			major_pos   = '0;
			minor_pos   = '0;
			major_end   = '0;
			major_delta = '0;
			minor_delta = '0;
			err_acc     = '0;
			minor_down  = 1'b0;
			swapped     = 1'b0;
			active      = 1'b0;
			color       = '0;
			errors      = 0;
		endfunction

		function void set_screen(int w, int h);
			screen_w = w & 'h7FF;
			screen_h = h & 'h7FF;
		endfunction

		function int magnitude(int v);
			return (v < 0) ? -v : v;
		endfunction

		// Called once per accepted request; a step on an active line owes one pixel.
		function void take_request(brl_cmd_t r);
			int ax, ay, bx, by;
			int p0, q0, p1, q1, t, x, y;
			bit steep, last;
			brl_pix_t px;
			if (r.command == CMD_LOAD) begin
				// endpoints are cut to the coordinate width, then sign extended
				ax = int'(coord_t'(r.start_x));
				ay = int'(coord_t'(r.start_y));
				bx = int'(coord_t'(r.end_x));
				by = int'(coord_t'(r.end_y));
				// steepness from unwrapped differences
				steep = magnitude(by - ay) > magnitude(bx - ax);
				if (steep) begin
					p0 = ay; q0 = ax; p1 = by; q1 = bx;
				end else begin
					p0 = ax; q0 = ay; p1 = bx; q1 = by;
				end
				if (p0 > p1) begin
					t = p0; p0 = p1; p1 = t;
					t = q0; q0 = q1; q1 = t;
				end
				// deltas wrap; a very long line may end up with a negative delta
				major_delta = coord_t'(p1 - p0);
				minor_delta = coord_t'(magnitude(q1 - q0));
				err_acc     = coord_t'(int'(major_delta) / 2);
				minor_down  = !(q0 < q1);
				swapped     = steep;
				major_pos   = coord_t'(p0);
				minor_pos   = coord_t'(q0);
				major_end   = coord_t'(p1);
				color       = r.line_color;
				active      = 1'b1;
				return;
			end
			if (!active)
				return;
			x = swapped ? int'(minor_pos) : int'(major_pos);
			y = swapped ? int'(major_pos) : int'(minor_pos);
			last = major_pos >= major_end;
			px.pixel_x     = coord_t'(x);
			px.pixel_y     = coord_t'(y);
			px.pixel_color = color;
			px.on_screen   = (x >= 0) && (x < screen_w) && (y >= 0) && (y < screen_h);
			px.last_pixel  = last;
			expected_pixels.push_back(px);
			err_acc = coord_t'(int'(err_acc) - int'(minor_delta));
			if (err_acc < 0) begin
				minor_pos = coord_t'(int'(minor_pos) + (minor_down ? -1 : 1));
				err_acc   = coord_t'(int'(err_acc) + int'(major_delta));
			end
			// last pixel reached by compare, so a line ending at the top coordinate stops
			if (last)
				active = 1'b0;
			else
				major_pos = coord_t'(int'(major_pos) + 1);
		endfunction

		function void note_mismatch(string field, int want, int got);
			if (want != got) begin
				errors++;
				$error("%s: expected %0d, got %0d", field, want, got);
			end
		endfunction

		function void check_pixel(brl_pix_t got);
			brl_pix_t want;
			if (expected_pixels.size() == 0) begin
				errors++;
				$error("unexpected pixel x %0d y %0d", got.pixel_x, got.pixel_y);
				return;
			end
			want = expected_pixels.pop_front();
			note_mismatch("pixel_x", int'(want.pixel_x), int'(got.pixel_x));
			note_mismatch("pixel_y", int'(want.pixel_y), int'(got.pixel_y));
			note_mismatch("pixel_color", int'(want.pixel_color), int'(got.pixel_color));
			note_mismatch("on_screen", int'(want.on_screen), int'(got.on_screen));
			note_mismatch("last_pixel", int'(want.last_pixel), int'(got.last_pixel));
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cmd_valid;
	logic                   cmd_ready;
	brl_cmd_t               cmd;
	logic                   pix_valid;
	logic                   pix_ready;
	brl_pix_t               pix;
	logic                   cfg_we;
	logic                   cfg_index;
	logic [SCREEN_BITS-1:0] cfg_data;

	line_pixel_scoreboard board;
	int burst_left;         // requests left in the current sender burst
	int requests_sent;
	int pixels_checked;

	bresenham_line_rasterizer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("== FAIL ==");
		$finish;
	end

	function automatic logic [15:0] rand16();
		return 16'($urandom);
	endfunction

	function automatic int rand_coord();
		return int'(coord_t'($urandom));
	endfunction

	// A coordinate within a few steps of the top or bottom of the signed range.
	function automatic int extreme_coord(bit top);
		return top ? 32767 - int'($urandom_range(0, 9)) : -32768 + int'($urandom_range(0, 9));
	endfunction

	// Offer one request and wait for it to be taken. Sender pacing is bursts
	// with random gaps; valid only drops in a gap, never between back-to-back
	// requests of a burst.
	task automatic send_request(input brl_cmd_t r);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		cmd       <= r;
		cmd_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cmd_ready);
		board.take_request(r);
		burst_left--;
		requests_sent++;
	endtask

	// Step request; the endpoint fields are don't-care, so fill them with noise.
	task automatic send_step();
		brl_cmd_t r;
		r.command    = CMD_STEP;
		r.start_x    = rand16();
		r.start_y    = rand16();
		r.end_x      = rand16();
		r.end_y      = rand16();
		r.line_color = rand16();
		send_request(r);
	endtask

	// Load a line, then walk it for the given number of steps.
	task automatic send_line(input int x0, input int y0, input int x1, input int y1,
			input logic [15:0] line_col, input int steps);
		brl_cmd_t r;
		r.command    = CMD_LOAD;
		r.start_x    = coord_t'(x0);
		r.start_y    = coord_t'(y0);
		r.end_x      = coord_t'(x1);
		r.end_y      = coord_t'(y1);
		r.line_color = line_col;
		send_request(r);
		repeat (steps) send_step();
	endtask

	// Stop offering, wait for every owed pixel, then let the block settle.
	task automatic drain_pixels();
		cmd_valid <= 1'b0;
		while (board.expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Both clip registers, written back to back; only called with the block idle.
	task automatic set_screen(input int w, input int h);
		cfg_we    <= 1'b1;
		cfg_index <= REG_SCREEN_WIDTH;
		cfg_data  <= SCREEN_BITS'(w);
		@(posedge clk);
		cfg_index <= REG_SCREEN_HEIGHT;
		cfg_data  <= SCREEN_BITS'(h);
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_screen(w, h);
	endtask

	// Mostly complete short lines around the screen; the rest is noise loads,
	// lines near the ends of the coordinate range, cut-short walks and stray steps.
	task automatic run_random_phase(input int n_requests);
		int target, kind, x0, y0, x1, y1, len, steps;
		bit side;
		target = requests_sent + n_requests;
		while (requests_sent < target) begin
			kind = $urandom_range(0, 99);
			if (kind < 72) begin
				x0 = $urandom_range(0, 1200) - 80;
				y0 = $urandom_range(0, 1200) - 80;
				x1 = x0 + $urandom_range(0, 80) - 40;
				y1 = y0 + $urandom_range(0, 80) - 40;
				if ($urandom_range(0, 24) == 0)
					x1 = x0 + ($urandom_range(0, 400) - 200) * 5;
				len = board.magnitude(x1 - x0);
				if (board.magnitude(y1 - y0) > len)
					len = board.magnitude(y1 - y0);
				len++;
				case ($urandom_range(0, 9))
					0: begin
						steps = $urandom_range(0, len - 1);   // cut short, next load replaces
					end
					1: begin
						steps = len + $urandom_range(1, 3);   // trailing steps on an idle block
					end
					default: begin
						steps = len;
					end
				endcase
				send_line(x0, y0, x1, y1, rand16(), steps);
			end else if (kind < 84) begin
				send_line(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand16(),
					$urandom_range(0, 4));
			end else if (kind < 94) begin
				side = $urandom_range(0, 1);
				x0 = extreme_coord(side);
				x1 = extreme_coord(($urandom_range(0, 3) == 0) ? !side : side);
				side = $urandom_range(0, 1);
				y0 = extreme_coord(side);
				y1 = extreme_coord(($urandom_range(0, 3) == 0) ? !side : side);
				len = board.magnitude(x1 - x0);
				if (board.magnitude(y1 - y0) > len)
					len = board.magnitude(y1 - y0);
				len++;
				send_line(x0, y0, x1, y1, rand16(), (len <= 20) ? len : $urandom_range(0, 6));
			end else begin
				send_step();
			end
		end
	endtask

	// Pixel side: checks every taken pixel and stalls on its own schedule.
	// Once, it holds off for a long stretch so requests back up.
	initial begin : pixel_sink
		int  ready_mode;
		int  mode_left;
		int  cycle_count;
		bit  hold_done;
		pix_ready   = 1'b0;
		ready_mode  = 0;
		mode_left   = 0;
		cycle_count = 0;
		hold_done   = 1'b0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (pix_valid && pix_ready) begin
				board.check_pixel(pix);
				pixels_checked++;
			end
			if (!hold_done && pixels_checked >= HOLD_AFTER) begin
				hold_done = 1'b1;
				pix_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			if (mode_left == 0) begin
				ready_mode = $urandom_range(0, 3);
				mode_left  = $urandom_range(20, 80);
			end
			mode_left--;
			case (ready_mode)
				0: begin
					pix_ready <= 1'b1;                            // no stalls
				end
				1: begin
					pix_ready <= 1'($urandom_range(0, 1));
				end
				2: begin
					pix_ready <= (cycle_count % 4) == 0;          // drains one in four
				end
				default: begin
					pix_ready <= ($urandom_range(0, 9) != 0);
				end
			endcase
		end
	end

	initial begin
		board          = new();
		burst_left     = 0;
		requests_sent  = 0;
		pixels_checked = 0;
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '0;
		cfg_we    = 1'b0;
		cfg_index = REG_SCREEN_WIDTH;
		cfg_data  = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed lines at the reset screen size.
		send_step();                                            // step with no line: no pixel
		send_line(0, 0, 0, 0, 16'hFFFF, 2);                     // single pixel, then idle step
		send_line(3, -1, -1, 1, 16'h0000, 5);                   // reversed, minor axis going down
		send_line(479, 319, 480, 322, 16'h5555, 4);             // steep, across the screen corner
		send_line(32767, -32768, 32764, -32768, 16'hAAAA, 4);   // ends at top coordinate
		send_line(-32768, -32768, 32767, 32767, 16'h8001, 2);   // full-span diagonal, wrapped deltas
		send_line(-32768, 32767, 32767, -32768, 16'h7FFE, 1);   // replaces the line above mid-walk

		// Random phases, each with its own clip window. Writes only with the block idle.
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				drain_pixels();
				case (ph)
					1: set_screen(1, 1);
					2: set_screen(1024, 1024);
					3: set_screen(0, 2047);       // zero width: everything clipped
					4: set_screen(2047, 0);       // zero height
					default: set_screen($urandom_range(1, 1024), $urandom_range(1, 1024));
				endcase
			end
			run_random_phase(PHASE_REQUESTS);
		end
		drain_pixels();

		if (board.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ files.f @@
sv/brl_pkg.sv
sv/brl_setup.sv
sv/brl_step.sv
sv/bresenham_line_rasterizer.sv
sim/bresenham_line_rasterizer_tb.sv
